FILE: design/bli_pkg.sv
package bli_pkg;

  // list geometry
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // field widths
  localparam int REQ_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  // width used to compare a position against the count
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_DEL_FRONT = 3'd2,
    REQ_DEL_END   = 3'd3,
    REQ_DEL_POS   = 3'd4
  } req_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

FILE: design/bli_ctrl.sv
module bli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bli_pkg::ctrl_cmd_t  cmd
);

  bli_pkg::state_t state_r;
  bli_pkg::state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bli_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = bli_pkg::S_EXEC;
        end
      end
      bli_pkg::S_EXEC: begin
        state_nxt = bli_pkg::S_RESP;
      end
      bli_pkg::S_RESP: begin
        if (out_tready) begin
          state_nxt = bli_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bli_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bli_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs
  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      bli_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      bli_pkg::S_EXEC: begin
        cmd.execute = 1'b1;
      end
      bli_pkg::S_RESP: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/bli_datapath.sv
module bli_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bli_pkg::ctrl_cmd_t          cmd,
  input  logic [bli_pkg::REQ_W-1:0]   req_in,
  input  logic [bli_pkg::VALUE_W-1:0] value_in,
  input  logic [bli_pkg::POS_W-1:0]   pos_in,
  output logic [bli_pkg::STAT_W-1:0]  res_status,
  output logic [bli_pkg::VALUE_W-1:0] res_removed,
  output logic [bli_pkg::COUNT_W-1:0] res_count
);

  // captured request
  logic [bli_pkg::REQ_W-1:0]   req_r;
  logic [bli_pkg::VALUE_W-1:0] val_r;
  logic [bli_pkg::POS_W-1:0]   pos_r;

  // entry cells and occupancy
  logic [bli_pkg::VALUE_W-1:0] cells_r   [bli_pkg::DEPTH];
  logic [bli_pkg::VALUE_W-1:0] cells_nxt [bli_pkg::DEPTH];
  logic [bli_pkg::CNT_W-1:0]   occ_r;
  logic [bli_pkg::CNT_W-1:0]   occ_nxt;

  // result register
  logic [bli_pkg::STAT_W-1:0]  status_r;
  logic [bli_pkg::STAT_W-1:0]  status_nxt;
  logic [bli_pkg::VALUE_W-1:0] removed_r;
  logic [bli_pkg::VALUE_W-1:0] removed_nxt;
  logic [bli_pkg::COUNT_W-1:0] count_r;

  // decoded operation
  logic                        do_ins_front;
  logic                        do_ins_end;
  logic                        do_del;
  logic [bli_pkg::IDX_W-1:0]   del_idx;
  logic                        full;
  logic                        empty;
  logic [bli_pkg::CMP_W-1:0]   pos_ext;
  logic [bli_pkg::CMP_W-1:0]   occ_ext;

  assign full    = (occ_r == bli_pkg::CNT_W'(bli_pkg::DEPTH));
  assign empty   = (occ_r == '0);
  assign pos_ext = bli_pkg::CMP_W'(pos_r);
  assign occ_ext = bli_pkg::CMP_W'(occ_r);

  // request decode, checks and new count
  always_comb begin
    status_nxt   = bli_pkg::STAT_OK;
    do_ins_front = 1'b0;
    do_ins_end   = 1'b0;
    do_del       = 1'b0;
    del_idx      = '0;
    occ_nxt      = occ_r;
    case (req_r)
      bli_pkg::REQ_INS_FRONT: begin
        if (full) begin
          status_nxt = bli_pkg::STAT_FULL;
        end else begin
          do_ins_front = 1'b1;
          occ_nxt      = occ_r + bli_pkg::CNT_W'(1);
        end
      end
      bli_pkg::REQ_INS_END: begin
        if (full) begin
          status_nxt = bli_pkg::STAT_FULL;
        end else begin
          do_ins_end = 1'b1;
          occ_nxt    = occ_r + bli_pkg::CNT_W'(1);
        end
      end
      bli_pkg::REQ_DEL_FRONT: begin
        if (empty) begin
          status_nxt = bli_pkg::STAT_EMPTY;
        end else begin
          do_del  = 1'b1;
          del_idx = '0;
          occ_nxt = occ_r - bli_pkg::CNT_W'(1);
        end
      end
      bli_pkg::REQ_DEL_END: begin
        if (empty) begin
          status_nxt = bli_pkg::STAT_EMPTY;
        end else begin
          do_del  = 1'b1;
          del_idx = bli_pkg::IDX_W'(occ_r - bli_pkg::CNT_W'(1));
          occ_nxt = occ_r - bli_pkg::CNT_W'(1);
        end
      end
      bli_pkg::REQ_DEL_POS: begin
        if (empty) begin
          status_nxt = bli_pkg::STAT_EMPTY;
        end else if (pos_r == '0) begin
          status_nxt = bli_pkg::STAT_INVALID;
        end else if (pos_ext > occ_ext) begin
          status_nxt = bli_pkg::STAT_RANGE;
        end else begin
          do_del  = 1'b1;
          del_idx = bli_pkg::IDX_W'(pos_ext - bli_pkg::CMP_W'(1));
          occ_nxt = occ_r - bli_pkg::CNT_W'(1);
        end
      end
      default: begin
        status_nxt = bli_pkg::STAT_OK;
      end
    endcase
  end

  // removed value, one read of the cell row
  always_comb begin
    removed_nxt = '0;
    if (do_del) begin
      removed_nxt = cells_r[del_idx];
    end
  end

  // per-cell next value: shift toward the end, append, or close the gap
  for (genvar g = 0; g < bli_pkg::DEPTH; g++) begin : g_cell
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_ins_front) begin
        if (g == 0) begin
          cells_nxt[g] = val_r;
        end else begin
          cells_nxt[g] = cells_r[(g == 0) ? 0 : g - 1];
        end
      end else if (do_ins_end) begin
        if (bli_pkg::CNT_W'(g) == occ_r) begin
          cells_nxt[g] = val_r;
        end
      end else if (do_del) begin
        if ((g < bli_pkg::DEPTH - 1) && (bli_pkg::IDX_W'(g) >= del_idx)) begin
          cells_nxt[g] = cells_r[(g < bli_pkg::DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  // request capture on an input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_in;
      val_r <= value_in;
      pos_r <= pos_in;
    end
  end

  // cell row update
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      cells_r <= cells_nxt;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.execute) begin
      occ_r <= occ_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      count_r   <= bli_pkg::COUNT_W'(occ_nxt);
    end
  end

  assign res_status  = status_r;
  assign res_removed = removed_r;
  assign res_count   = count_r;

  // occupancy never exceeds the cell row
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= bli_pkg::CNT_W'(bli_pkg::DEPTH))
    else $error("occupancy beyond depth");

  // insert into a full list is refused and reported
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && full &&
    (req_r == bli_pkg::REQ_INS_FRONT || req_r == bli_pkg::REQ_INS_END)
    |=> status_r == bli_pkg::STAT_FULL && $stable(occ_r))
    else $error("insert into full list not refused");

  // a successful delete drops the count by one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && do_del |=> occ_r == $past(occ_r) - bli_pkg::CNT_W'(1))
    else $error("delete did not drop count");

  // occupancy only moves while a request executes
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.execute |=> $stable(occ_r))
    else $error("occupancy changed outside execute");

endmodule

FILE: design/bounded_list_insert_delete.sv
// bounded ordered list with front/end insert and front/end/position delete
// after the input transfer the request is captured, executed on the cell row in
// S_EXEC with its result registered, and out_tvalid is then raised in S_RESP
// a new request is not taken until the result transfer has completed
// (capture, execute on the cell row, respond; the controller handles one at a time)
// reset: synchronous active-low rst_n empties the list and returns to idle;
// cell contents are not cleared and are only read once written
module bounded_list_insert_delete (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bli_pkg::IN_TDATA_W-1:0]  in_tdata,   // value[31:0], position[39:32]
  input  logic [bli_pkg::REQ_W-1:0]       in_tuser,   // req_type[2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bli_pkg::OUT_TDATA_W-1:0] out_tdata,  // removed_value[31:0], entry_count[36:32]
  output logic [bli_pkg::STAT_W-1:0]      out_tuser   // status[2:0]
);

  bli_pkg::ctrl_cmd_t           cmd;
  logic [bli_pkg::STAT_W-1:0]   res_status;
  logic [bli_pkg::VALUE_W-1:0]  res_removed;
  logic [bli_pkg::COUNT_W-1:0]  res_count;

  // handshake control
  bli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // cell row, occupancy and result register
  bli_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_in      (in_tuser),
    .value_in    (in_tdata[bli_pkg::VALUE_W-1:0]),
    .pos_in      (in_tdata[bli_pkg::VALUE_W +: bli_pkg::POS_W]),
    .res_status  (res_status),
    .res_removed (res_removed),
    .res_count   (res_count)
  );

  // pack the result transfer
  assign out_tdata = bli_pkg::OUT_TDATA_W'({res_count, res_removed});
  assign out_tuser = res_status;

endmodule
